// File: rtl/core/fwd_pkg.sv
package fwd_pkg;

    // Membership degrees and strengths are Q1.8 in 0..256.
    typedef logic [8:0] fwd_deg_t;

    typedef struct packed {
        fwd_deg_t cold;
        fwd_deg_t cool;
        fwd_deg_t norm;
        fwd_deg_t warm;
        fwd_deg_t hot;
        fwd_deg_t dry;
        fwd_deg_t moist;
        fwd_deg_t wet;
    } fwd_memb_t;

    typedef struct packed {
        fwd_deg_t s_str;
        fwd_deg_t m_str;
        fwd_deg_t l_str;
    } fwd_str_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SHORT  = 2'd0;
    localparam logic [1:0] CFG_MEDIUM = 2'd1;
    localparam logic [1:0] CFG_LONG   = 2'd2;

    // Ramp corners in Q8.8, extended to 18 signed bits.
    localparam logic signed [17:0] T_COLD_HI  = 18'sd0;
    localparam logic signed [17:0] T_COOL_LO  = 18'sd768;
    localparam logic signed [17:0] T_COOL_HI  = 18'sd3072;
    localparam logic signed [17:0] T_NORM_LO  = 18'sd3840;
    localparam logic signed [17:0] T_NORM_HI  = 18'sd6144;
    localparam logic signed [17:0] T_WARM_LO  = 18'sd6912;
    localparam logic signed [17:0] T_WARM_HI  = 18'sd9216;
    localparam logic signed [17:0] T_HOT_LO   = 18'sd9984;
    localparam logic signed [17:0] H_DRY_HI   = 18'sd2560;
    localparam logic signed [17:0] H_MOIST_LO = 18'sd5120;
    localparam logic signed [17:0] H_MOIST_HI = 18'sd10240;
    localparam logic signed [17:0] H_WET_LO   = 18'sd12800;

    localparam logic signed [17:0] TEMP_SPAN = 18'sd768;
    localparam logic signed [17:0] HUM_SPAN  = 18'sd2560;

    localparam fwd_deg_t DEG_ONE = 9'd256;

    // Ramp over three degrees: the degree is floor(d / 3), taken as
    // (d * 683) >> 11, which is exact for d below 768.
    function automatic fwd_deg_t ramp3(input logic signed [17:0] d);
        logic [20:0] prod;
        begin
            prod = 21'(d[9:0]) * 21'd683;
            if (d <= 18'sd0)
                ramp3 = '0;
            else if (d >= TEMP_SPAN)
                ramp3 = DEG_ONE;
            else
                ramp3 = {1'b0, prod[18:11]};
        end
    endfunction

    // Ramp over ten percent: floor(d / 10) as (d * 1639) >> 14, exact
    // for d below 2560.
    function automatic fwd_deg_t ramp10(input logic signed [17:0] d);
        logic [22:0] prod;
        begin
            prod = 23'(d[11:0]) * 23'd1639;
            if (d <= 18'sd0)
                ramp10 = '0;
            else if (d >= HUM_SPAN)
                ramp10 = DEG_ONE;
            else
                ramp10 = {1'b0, prod[21:14]};
        end
    endfunction

    function automatic fwd_deg_t min9(input fwd_deg_t a, input fwd_deg_t b);
        min9 = (a < b) ? a : b;
    endfunction

    function automatic fwd_deg_t max9(input fwd_deg_t a, input fwd_deg_t b);
        max9 = (a > b) ? a : b;
    endfunction

endpackage

// File: rtl/core/fwd_fuzzify.sv
// Fuzzification stage: all eight membership degrees, registered.
module fwd_fuzzify import fwd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [15:0]      temperature,
    input  logic [15:0]      humidity,
    output logic             out_valid,
    output fwd_memb_t        memb
);

    logic signed [17:0] t_ext;
    logic signed [17:0] h_ext;
    fwd_memb_t          memb_next;
    fwd_memb_t          memb_reg;
    logic               valid_reg;

    always_comb
    begin
        t_ext = {{2{temperature[15]}}, temperature};
        h_ext = {2'b00, humidity};
        memb_next.cold  = ramp3(T_COOL_LO - t_ext);
        memb_next.cool  = min9(ramp3(t_ext - T_COLD_HI), ramp3(T_NORM_LO - t_ext));
        memb_next.norm  = min9(ramp3(t_ext - T_COOL_HI), ramp3(T_WARM_LO - t_ext));
        memb_next.warm  = min9(ramp3(t_ext - T_NORM_HI), ramp3(T_HOT_LO - t_ext));
        memb_next.hot   = ramp3(t_ext - T_WARM_HI);
        memb_next.dry   = ramp10(H_MOIST_LO - h_ext);
        memb_next.moist = min9(ramp10(h_ext - H_DRY_HI), ramp10(H_WET_LO - h_ext));
        memb_next.wet   = ramp10(h_ext - H_MOIST_HI);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        memb_reg <= memb_next;
    end

    assign out_valid = valid_reg;
    assign memb      = memb_reg;

endmodule

// File: rtl/core/fwd_rules.sv
// Rule stage: min for each rule, max for each output set, registered.
module fwd_rules import fwd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  fwd_memb_t memb,
    output logic      out_valid,
    output fwd_str_t  str
);

    fwd_str_t str_next;
    fwd_str_t str_reg;
    logic     valid_reg;

    always_comb
    begin
        // Moist and cold or cool, and wet with any temperature, give short.
        str_next.s_str = max9(max9(min9(memb.cold, memb.moist),
                                   min9(memb.cool, memb.moist)),
                              max9(max9(min9(memb.cold, memb.wet),
                                        min9(memb.cool, memb.wet)),
                                   max9(min9(memb.norm, memb.wet),
                                        max9(min9(memb.warm, memb.wet),
                                             min9(memb.hot, memb.wet)))));
        str_next.m_str = max9(min9(memb.norm, memb.moist),
                              max9(min9(memb.warm, memb.moist),
                                   min9(memb.hot, memb.moist)));
        str_next.l_str = max9(max9(min9(memb.cold, memb.dry),
                                   min9(memb.cool, memb.dry)),
                              max9(min9(memb.norm, memb.dry),
                                   max9(min9(memb.warm, memb.dry),
                                        min9(memb.hot, memb.dry))));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        str_reg <= str_next;
    end

    assign out_valid = valid_reg;
    assign str       = str_reg;

endmodule

// File: rtl/core/fwd_weight.sv
// Weighting: three products and the strength sum, then the numerator sum.
module fwd_weight import fwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  fwd_str_t    str_in,
    input  logic [7:0]  short_minutes,
    input  logic [7:0]  medium_minutes,
    input  logic [7:0]  long_minutes,
    output logic        out_valid,
    output fwd_str_t    str_out,
    output logic [17:0] num,
    output logic [9:0]  den
);

    logic [16:0] prod_s_reg;
    logic [16:0] prod_m_reg;
    logic [16:0] prod_l_reg;
    logic [9:0]  den_a_reg;
    fwd_str_t    str_a_reg;
    logic        valid_a_reg;
    logic [17:0] num_reg;
    logic [9:0]  den_b_reg;
    fwd_str_t    str_b_reg;
    logic        valid_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_s_reg <= 17'(str_in.s_str) * 17'(short_minutes);
        prod_m_reg <= 17'(str_in.m_str) * 17'(medium_minutes);
        prod_l_reg <= 17'(str_in.l_str) * 17'(long_minutes);
        den_a_reg  <= 10'(str_in.s_str) + 10'(str_in.m_str) + 10'(str_in.l_str);
        str_a_reg  <= str_in;
        num_reg    <= 18'(prod_s_reg) + 18'(prod_m_reg) + 18'(prod_l_reg);
        den_b_reg  <= den_a_reg;
        str_b_reg  <= str_a_reg;
    end

    assign out_valid = valid_b_reg;
    assign str_out   = str_b_reg;
    assign num       = num_reg;
    assign den       = den_b_reg;

endmodule

// File: rtl/core/fwd_div.sv
// Pipelined restoring divider: (num * 256) / den, one quotient bit per stage.
// The quotient always fits 16 bits, so the top ten dividend bits start as
// the partial remainder.
module fwd_div import fwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  fwd_str_t    str_in,
    input  logic [17:0] num,
    input  logic [9:0]  den,
    output logic        out_valid,
    output fwd_str_t    str_out,
    output logic [15:0] quotient
);

    localparam int unsigned STAGES = 16;

    logic [9:0]  rem_src   [STAGES];
    logic [15:0] low_src   [STAGES];
    logic [15:0] quo_src   [STAGES];
    logic [9:0]  den_src   [STAGES];
    logic        zero_src  [STAGES];
    fwd_str_t    str_src   [STAGES];
    logic        valid_src [STAGES];

    logic [9:0]  rem_reg   [STAGES];
    logic [15:0] low_reg   [STAGES];
    logic [15:0] quo_reg   [STAGES];
    logic [9:0]  den_reg   [STAGES];
    logic        zero_reg  [STAGES];
    fwd_str_t    str_reg   [STAGES];
    logic        valid_reg [STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [10:0] trial;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign rem_src[k]   = num[17:8];
            assign low_src[k]   = {num[7:0], 8'd0};
            assign quo_src[k]   = '0;
            assign den_src[k]   = den;
            assign zero_src[k]  = (den == '0);
            assign str_src[k]   = str_in;
            assign valid_src[k] = in_valid;
        end
        else
        begin : g_next
            assign rem_src[k]   = rem_reg[k-1];
            assign low_src[k]   = low_reg[k-1];
            assign quo_src[k]   = quo_reg[k-1];
            assign den_src[k]   = den_reg[k-1];
            assign zero_src[k]  = zero_reg[k-1];
            assign str_src[k]   = str_reg[k-1];
            assign valid_src[k] = valid_reg[k-1];
        end

        assign trial = {rem_src[k], low_src[k][15]};
        assign ge    = (trial >= {1'b0, den_src[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= valid_src[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? 10'(trial - {1'b0, den_src[k]}) : trial[9:0];
            low_reg[k]  <= {low_src[k][14:0], 1'b0};
            quo_reg[k]  <= {quo_src[k][14:0], ge};
            den_reg[k]  <= den_src[k];
            zero_reg[k] <= zero_src[k];
            str_reg[k]  <= str_src[k];
        end
    end

    // A zero strength sum gives a zero duration.
    assign quotient  = zero_reg[STAGES-1] ? '0 : quo_reg[STAGES-1];
    assign out_valid = valid_reg[STAGES-1];
    assign str_out   = str_reg[STAGES-1];

endmodule

// File: rtl/core/fuzzy_watering_duration_top.sv
// Fuzzy watering-duration controller.
//
// A sample transfer is taken at each rising clock edge at which start is
// high; busy is always low, so a new temperature and humidity pair may be
// offered in every cycle. The result transfer appears on duration and the
// three strength ports for exactly one cycle, marked by done. Throughput is
// one sample per cycle. The pipeline has one stage of fuzzification, one
// of rule evaluation, two of weighting and sixteen of the restoring divider,
// which settles one quotient bit per stage. Results leave in the order the
// samples came in. The receiver cannot stall the block, so every result
// must be taken in the cycle it is shown. The minute values are written
// through cfg_we, cfg_index and cfg_data, one register per edge; the user
// must write them only while no sample is in flight, which the block
// itself does not enforce. An index of three is ignored. Reset clears
// every stage valid bit, so nothing emerges from the pipeline afterwards,
// and returns the minute values to 20, 40 and 60.
module fuzzy_watering_duration_top import fwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] temperature,
    input  logic [15:0] humidity,
    output logic        done,
    output logic [15:0] duration,
    output logic [8:0]  short_strength,
    output logic [8:0]  medium_strength,
    output logic [8:0]  long_strength,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [7:0] SHORT_RESET  = 8'd20;
    localparam logic [7:0] MEDIUM_RESET = 8'd40;
    localparam logic [7:0] LONG_RESET   = 8'd60;

    logic [7:0] short_min_reg;
    logic [7:0] medium_min_reg;
    logic [7:0] long_min_reg;

    logic        fz_valid;
    fwd_memb_t   fz_memb;
    logic        ru_valid;
    fwd_str_t    ru_str;
    logic        wt_valid;
    fwd_str_t    wt_str;
    logic [17:0] wt_num;
    logic [9:0]  wt_den;
    fwd_str_t    dv_str;

    // The pipeline never holds back, so the block is never busy.
    assign busy = 1'b0;

    // Configuration registers: plain writes, an out-of-range index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg  <= SHORT_RESET;
            medium_min_reg <= MEDIUM_RESET;
            long_min_reg   <= LONG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHORT:  short_min_reg  <= cfg_data;
                CFG_MEDIUM: medium_min_reg <= cfg_data;
                CFG_LONG:   long_min_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    fwd_fuzzify u_fuzzify (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .temperature (temperature),
        .humidity    (humidity),
        .out_valid   (fz_valid),
        .memb        (fz_memb)
    );

    fwd_rules u_rules (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fz_valid),
        .memb      (fz_memb),
        .out_valid (ru_valid),
        .str       (ru_str)
    );

    fwd_weight u_weight (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (ru_valid),
        .str_in         (ru_str),
        .short_minutes  (short_min_reg),
        .medium_minutes (medium_min_reg),
        .long_minutes   (long_min_reg),
        .out_valid      (wt_valid),
        .str_out        (wt_str),
        .num            (wt_num),
        .den            (wt_den)
    );

    fwd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wt_valid),
        .str_in    (wt_str),
        .num       (wt_num),
        .den       (wt_den),
        .out_valid (done),
        .str_out   (dv_str),
        .quotient  (duration)
    );

    assign short_strength  = dv_str.s_str;
    assign medium_strength = dv_str.m_str;
    assign long_strength   = dv_str.l_str;

endmodule

// File: tb/watering_duration_checker.sv
module watering_duration_checker import fwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] temperature,
    input  logic [15:0] humidity,
    input  logic        done,
    input  logic [15:0] duration,
    input  logic [8:0]  short_strength,
    input  logic [8:0]  medium_strength,
    input  logic [8:0]  long_strength,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [15:0] minutes_q8;
        fwd_str_t    strength;
    } watering_t;

    localparam int ONE = 256;

    // Ramp corners in Q8.8, degrees and percent.
    localparam int DEG_0  = 0;
    localparam int DEG_3  = 3 * 256;
    localparam int DEG_12 = 12 * 256;
    localparam int DEG_15 = 15 * 256;
    localparam int DEG_24 = 24 * 256;
    localparam int DEG_27 = 27 * 256;
    localparam int DEG_36 = 36 * 256;
    localparam int DEG_39 = 39 * 256;
    localparam int PCT_10 = 10 * 256;
    localparam int PCT_20 = 20 * 256;
    localparam int PCT_40 = 40 * 256;
    localparam int PCT_50 = 50 * 256;

    logic [7:0] short_min;
    logic [7:0] medium_min;
    logic [7:0] long_min;
    watering_t  pending_readings [$];
    watering_t  want;
    int         errors;

    function automatic int rising(input int x, input int lo, input int hi);
        if (x <= lo)
            return 0;
        if (x >= hi)
            return ONE;
        return ((x - lo) * ONE) / (hi - lo);
    endfunction

    function automatic int falling(input int x, input int lo, input int hi);
        if (x <= lo)
            return ONE;
        if (x >= hi)
            return 0;
        return ((hi - x) * ONE) / (hi - lo);
    endfunction

    function automatic int lesser(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int greater(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Fuzzifies one sample, fires the rule table and forms the weighted average.
    function automatic watering_t predict_watering(input logic [15:0] temp_raw,
                                                   input logic [15:0] hum_raw,
                                                   input logic [7:0]  short_m,
                                                   input logic [7:0]  medium_m,
                                                   input logic [7:0]  long_m);
        int        t;
        int        h;
        int        band [5];
        int        dry;
        int        moist;
        int        wet;
        int        s_w;
        int        m_w;
        int        l_w;
        int        num;
        int        den;
        int        quot;
        watering_t r;
        t = $signed(temp_raw);
        h = int'(hum_raw);
        band[0] = falling(t, DEG_0, DEG_3);
        band[1] = lesser(rising(t, DEG_0, DEG_3), falling(t, DEG_12, DEG_15));
        band[2] = lesser(rising(t, DEG_12, DEG_15), falling(t, DEG_24, DEG_27));
        band[3] = lesser(rising(t, DEG_24, DEG_27), falling(t, DEG_36, DEG_39));
        band[4] = rising(t, DEG_36, DEG_39);
        dry   = falling(h, PCT_10, PCT_20);
        moist = lesser(rising(h, PCT_10, PCT_20), falling(h, PCT_40, PCT_50));
        wet   = rising(h, PCT_40, PCT_50);
        s_w = 0;
        m_w = 0;
        l_w = 0;
        for (int i = 0; i < 5; i++)
        begin
            // Moist soil waters briefly when cold or cool, moderately otherwise.
            if (i < 2)
                s_w = greater(s_w, lesser(band[i], moist));
            else
                m_w = greater(m_w, lesser(band[i], moist));
            s_w = greater(s_w, lesser(band[i], wet));
            l_w = greater(l_w, lesser(band[i], dry));
        end
        num = s_w * int'(short_m) + m_w * int'(medium_m) + l_w * int'(long_m);
        den = s_w + m_w + l_w;
        quot = (den != 0) ? (num * ONE) / den : 0;
        r.minutes_q8     = quot[15:0];
        r.strength.s_str = s_w[8:0];
        r.strength.m_str = m_w[8:0];
        r.strength.l_str = l_w[8:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_readings.delete();
            short_min  = 8'd20;
            medium_min = 8'd40;
            long_min   = 8'd60;
            errors     = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_readings.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"Unexpected result transfer: ",
                                  "duration=%0d short=%0d medium=%0d long=%0d"},
                                 duration, short_strength, medium_strength,
                                 long_strength);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (duration !== want.minutes_q8 ||
                        short_strength !== want.strength.s_str ||
                        medium_strength !== want.strength.m_str ||
                        long_strength !== want.strength.l_str)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"Result mismatch: expected duration=%0d ",
                                      "short=%0d medium=%0d long=%0d, ",
                                      "got duration=%0d short=%0d medium=%0d long=%0d"},
                                     want.minutes_q8, want.strength.s_str,
                                     want.strength.m_str, want.strength.l_str,
                                     duration, short_strength,
                                     medium_strength, long_strength);
                    end
                end
            end
            if (start && !busy)
                pending_readings.push_back(predict_watering(temperature, humidity,
                                                            short_min, medium_min, long_min));
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SHORT:  short_min  = cfg_data;
                    CFG_MEDIUM: medium_min = cfg_data;
                    CFG_LONG:   long_min   = cfg_data;
                    default:    ;
                endcase
            end
        end
        mismatches  <= errors;
        outstanding <= pending_readings.size();
    end

endmodule

// File: tb/tb.sv
// Top of the testbench for the fuzzy watering-duration controller.
//
// This module only makes stimulus and gives the verdict. The checker beside
// the block watches every sample transfer, result transfer and register
// write, predicts each result and compares it, and hands back the number of
// mismatches together with the number of results still awaited.
module tb;
    import fwd_pkg::*;

    // Depth of the block's pipeline.
    localparam int PIPE_DEPTH   = 20;
    // Cycles without any transfer or register write before the run is abandoned.
    // The slowest correct stretch is a full sender gap followed by a
    // drain of the pipeline.
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASES       = 7;
    // The one register index that the block has no register behind.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic        done;
    logic [15:0] duration;
    logic [8:0]  short_strength;
    logic [8:0]  medium_strength;
    logic [8:0]  long_strength;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    int          mismatches;
    int          outstanding;
    int          quiet_cycles = 0;
    bit          steady = 0;

    // Temperatures at and just beside the ramp ends, ramp midpoints and the
    // extremes of the signed range.
    logic [15:0] temp_corners [0:16] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                                         16'h0001, 16'h0180, 16'h02FF, 16'h0300,
                                         16'h0C00, 16'h0D80, 16'h0F00, 16'h1800,
                                         16'h1980, 16'h1B00, 16'h2400, 16'h2580,
                                         16'h2700};
    // Humidities at the ramp ends and midpoints, and both ends of the unsigned range.
    logic [15:0] hum_corners [0:7] = '{16'h0000, 16'h0A00, 16'h0F00, 16'h1400,
                                       16'h2800, 16'h2D00, 16'h3200, 16'hFFFF};

    fuzzy_watering_duration_top dut (.*);

    watering_duration_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Most temperatures fall in the span where the sets overlap, some sit
    // right beside a ramp end, and the rest cover the whole signed range so
    // that every bit of the port is exercised.
    function automatic logic [15:0] pick_temperature();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return 16'($urandom_range(0, 50 * 256) - 5 * 256);
        if (roll < 9)
            return 16'(temp_corners[$urandom_range(0, 16)] + $urandom_range(0, 4) - 2);
        return 16'($urandom);
    endfunction

    // Humidity likewise, mostly up to sixty percent, with the odd reading far
    // beyond saturation.
    function automatic logic [15:0] pick_humidity();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return 16'($urandom_range(0, 60 * 256));
        if (roll < 9)
            return 16'(hum_corners[$urandom_range(0, 7)] + $urandom_range(0, 4) - 2);
        return 16'($urandom);
    endfunction

    // Offers one sample and returns at the edge that takes it. Before the
    // offer the sender idles for a random number of cycles, except during
    // steady stretches, which come and go at random, when samples follow
    // back to back. Start is left high afterwards so that a following sample
    // with no gap continues the burst without start being lowered.
    task automatic send_sample(input logic [15:0] t, input logic [15:0] h);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        temperature <= t;
        humidity    <= h;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stops offering samples and waits until every expected result transfer
    // has been seen, then keeps waiting so that a stray result still in the
    // pipeline would show up before the block is touched again.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    // Writes the three minute values while the block is idle. A write to the
    // spare index is slipped in between; the block has to ignore it.
    task automatic set_minutes(input logic [7:0] short_m, input logic [7:0] medium_m,
                               input logic [7:0] long_m);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SHORT;
        cfg_data  <= short_m;
        @(posedge clk);
        cfg_index <= CFG_MEDIUM;
        cfg_data  <= medium_m;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_index <= CFG_LONG;
        cfg_data  <= long_m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int i;
        int phase;
        int n;
        rst_n       = 1'b0;
        start       = 1'b0;
        temperature = '0;
        humidity    = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_SHORT;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples with the minute values left at their reset
        // settings. The two corner lists have coprime lengths, so every humidity
        // corner meets several temperature corners and every temperature corner
        // meets a humidity corner: frost and heat at the ends of the signed range,
        // humidity beyond saturation, and every ramp end and midpoint.
        for (i = 0; i < 25; i++)
            send_sample(temp_corners[i % 17], hum_corners[i % 8]);

        // Random samples under several minute settings, the extremes among
        // them. Each change of setting waits for the pipeline to empty, which
        // is also where the sender holds off until every result is in.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       ;
                1:       set_minutes(8'd0, 8'd0, 8'd0);
                2:       set_minutes(8'd255, 8'd255, 8'd255);
                3:       set_minutes(8'd0, 8'd128, 8'd255);
                4:       set_minutes(8'd255, 8'd1, 8'd0);
                default: set_minutes(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
                send_sample(pick_temperature(), pick_humidity());
        end

        drain_results();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
